@@ sv/cfp_pkg.sv @@
package cfp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEVEL_W = 10;
   localparam int unsigned CODE_W  = 2;

   localparam logic [LEVEL_W-1:0] SETPOINT_START = LEVEL_W'(512);
   localparam logic [LEVEL_W-1:0] LEVEL_START    = LEVEL_W'(512);
   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = '1;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO     = '0;

   localparam logic [BYTE_W-1:0] LETTER_F    = 8'h46;
   localparam logic [BYTE_W-1:0] LETTER_B    = 8'h42;
   localparam logic [BYTE_W-1:0] LETTER_T    = 8'h54;
   localparam logic [BYTE_W-1:0] LETTER_D    = 8'h44;
   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'h53;

   typedef enum logic [CODE_W-1:0] {
      CMD_FORWARD  = 2'd0,
      CMD_BACKWARD = 2'd1,
      CMD_SETPOINT = 2'd2,
      CMD_DEADZONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      POS_IDLE   = 3'd0,
      POS_MARKER = 3'd1,
      POS_LOW    = 3'd2,
      POS_HIGH   = 3'd3,
      POS_STOP   = 3'd4
   } pos_type;

endpackage

@@ sv/cfp_if.sv @@
interface cfp_req_if import cfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_rsp_if import cfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  command_code;
   logic [LEVEL_W-1:0] forward_level;
   logic [LEVEL_W-1:0] backward_level;
   logic [LEVEL_W-1:0] setpoint_level;
   logic [LEVEL_W-1:0] deadzone_level;

   modport source (output valid, output command_code, output forward_level,
                   output backward_level, output setpoint_level,
                   output deadzone_level, input ready);
   modport sink   (input valid, input command_code, input forward_level,
                   input backward_level, input setpoint_level,
                   input deadzone_level, output ready);
endinterface

@@ sv/command_frame_parser.sv @@
// command frame parser
//
// req_chan carries received bytes, one per item, in arrival order. a frame
// is a command letter (F, B, T or D), marker 0xAA, value low byte, value
// high byte (low 2 bits used) and stop byte 'S'. bytes that are not a
// command letter are dropped while waiting; once a letter is seen the next
// four bytes always belong to the frame.
// rsp_chan carries one item per good frame: the command code and the four
// levels after the frame is applied. bad frames give no item.
// the item appears in the cycle after the stop byte is accepted.
// throughput: one byte per cycle unless stalled; frame state and levels
// are updated in a single pass of next-state logic from the accepted byte.
// the levels themselves are the result register: they change only at the
// end of a good frame, which needs the result slot to be free.
// reset: waits for a command letter, forward, backward and deadzone at 512,
// setpoint at SETPOINT_START, no result pending.
// stall: while a result waits, req_ready follows rsp_ready, so a stalled
// receiver holds the byte stream back without losing anything.
module command_frame_parser import cfp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cfp_req_if.sink  req_chan,
   cfp_rsp_if.source rsp_chan
);

   // frame state
   pos_type              pos_ff, pos_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 marker_ok_ff, marker_ok_in;
   logic [BYTE_W-1:0]    low_ff, low_in;
   logic [1:0]           high_ff, high_in;

   // levels, also the result payload
   logic [LEVEL_W-1:0]   fwd_ff, fwd_in;
   logic [LEVEL_W-1:0]   bwd_ff, bwd_in;
   logic [LEVEL_W-1:0]   set_ff, set_in;
   logic [LEVEL_W-1:0]   dz_ff, dz_in;

   // result slot
   logic                 rsp_valid_ff, rsp_valid_in;
   cmd_type              rsp_cmd_ff, rsp_cmd_in;

   logic                 accept;
   logic [BYTE_W-1:0]    rx;
   logic                 is_letter;
   cmd_type              letter_cmd;
   logic                 frame_done;
   logic [LEVEL_W-1:0]   value;

   // slot frees when empty or taken this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;
   assign value          = {high_ff, low_ff};

   always_comb begin
      is_letter  = 1'b1;
      letter_cmd = CMD_FORWARD;
      case (rx)
         LETTER_F: letter_cmd = CMD_FORWARD;
         LETTER_B: letter_cmd = CMD_BACKWARD;
         LETTER_T: letter_cmd = CMD_SETPOINT;
         LETTER_D: letter_cmd = CMD_DEADZONE;
         default:  is_letter  = 1'b0;
      endcase
   end

   assign frame_done = accept && (pos_ff == POS_STOP) && marker_ok_ff && (rx == STOP_BYTE);

   // next frame position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         case (pos_ff)
            POS_MARKER: pos_in = POS_LOW;
            POS_LOW:    pos_in = POS_HIGH;
            POS_HIGH:   pos_in = POS_STOP;
            POS_STOP:   pos_in = POS_IDLE;
            default:    pos_in = is_letter ? POS_MARKER : POS_IDLE;
         endcase
      end
   end

   // frame data, levels and result slot
   always_comb begin
      cmd_in       = cmd_ff;
      marker_ok_in = marker_ok_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      fwd_in       = fwd_ff;
      bwd_in       = bwd_ff;
      set_in       = set_ff;
      dz_in        = dz_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         case (pos_ff)
            POS_MARKER: marker_ok_in = (rx == MARKER_BYTE);
            POS_LOW:    low_in       = rx;
            POS_HIGH:   high_in      = rx[1:0];
            POS_STOP:   ;
            default: begin
               if (is_letter) begin
                  cmd_in       = letter_cmd;
                  marker_ok_in = 1'b0;
               end
            end
         endcase
      end

      if (frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = cmd_ff;
         case (cmd_ff)
            CMD_FORWARD: begin
               fwd_in = value;
               dz_in  = LEVEL_ZERO;
               bwd_in = LEVEL_MAX;
            end
            CMD_BACKWARD: begin
               bwd_in = value;
               dz_in  = LEVEL_ZERO;
               fwd_in = LEVEL_ZERO;
            end
            CMD_SETPOINT: begin
               set_in = value;
            end
            default: begin
               dz_in  = value;
               fwd_in = LEVEL_ZERO;
               bwd_in = LEVEL_MAX;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_IDLE;
         cmd_ff       <= CMD_FORWARD;
         marker_ok_ff <= 1'b0;
         low_ff       <= '0;
         high_ff      <= '0;
         fwd_ff       <= LEVEL_START;
         bwd_ff       <= LEVEL_START;
         set_ff       <= SETPOINT_START;
         dz_ff        <= LEVEL_START;
         rsp_valid_ff <= 1'b0;
         rsp_cmd_ff   <= CMD_FORWARD;
      end else begin
         pos_ff       <= pos_in;
         cmd_ff       <= cmd_in;
         marker_ok_ff <= marker_ok_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         fwd_ff       <= fwd_in;
         bwd_ff       <= bwd_in;
         set_ff       <= set_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_cmd_ff   <= rsp_cmd_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.command_code   = rsp_cmd_ff;
   assign rsp_chan.forward_level  = fwd_ff;
   assign rsp_chan.backward_level = bwd_ff;
   assign rsp_chan.setpoint_level = set_ff;
   assign rsp_chan.deadzone_level = dz_ff;

endmodule

@@ sv/cfp_checker.sv @@
module cfp_checker import cfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cfp_req_if.sink   req_chan,
   cfp_rsp_if.source rsp_chan
);

   logic req_acc;

   assign req_acc = req_chan.valid && req_chan.ready;

   // a stalled result keeps its command code, forward and deadzone levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.command_code) &&
         $stable(rsp_chan.forward_level) && $stable(rsp_chan.deadzone_level))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result present after reset");

   // a fresh result follows an accepted stop byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_chan.valid &&
         !($past(rsp_chan.valid) && !$past(rsp_chan.ready)) |->
         $past(req_acc) && $past(req_chan.rx_byte) == STOP_BYTE)
      else $error("result without stop byte");

   // forward command leaves deadzone cleared and backward at full scale
   a_fwd_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.command_code == CMD_FORWARD |->
         rsp_chan.deadzone_level == LEVEL_ZERO && rsp_chan.backward_level == LEVEL_MAX)
      else $error("forward levels wrong");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
